// ----- rtl/fem_pkg.sv -----
package fem_pkg;

  localparam int unsigned MAX_DOFS_DEF    = 16;
  localparam int unsigned MAX_QPOINTS_DEF = 16;
  localparam int unsigned FRAC_BITS_DEF   = 24;

  localparam int unsigned VAL_W = 32;
  localparam int unsigned ACC_W = 40;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [2:0] FUNC_LOAD_COEF   = 3'd0;
  localparam logic [2:0] FUNC_LOAD_SHAPE  = 3'd1;
  localparam logic [2:0] FUNC_LOAD_WEIGHT = 3'd2;
  localparam logic [2:0] FUNC_COMPUTE     = 3'd3;
  localparam logic [2:0] FUNC_READ        = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_DOF_COUNT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_QPOINT_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_JAC_ENABLE   = 2'd2;

  localparam logic signed [63:0] ACC_MAX = 64'sh0000_007F_FFFF_FFFF;
  localparam logic signed [63:0] ACC_MIN = -64'sh0000_0080_0000_0000;
  localparam logic signed [63:0] VAL_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] VAL_MIN = -64'sh0000_0000_8000_0000;

  function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [63:0] x);
    logic signed [63:0] r;
    if (x > ACC_MAX) r = ACC_MAX;
    else if (x < ACC_MIN) r = ACC_MIN;
    else r = x;
    return r[ACC_W-1:0];
  endfunction

  function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [63:0] x);
    logic signed [63:0] r;
    if (x > VAL_MAX) r = VAL_MAX;
    else if (x < VAL_MIN) r = VAL_MIN;
    else r = x;
    return r[VAL_W-1:0];
  endfunction

endpackage

// ----- rtl/fem_element_mass_assembly.sv -----
// Element mass assembly. Loads of coefficients, shape values and weights and
// ignored codes leave the block idle. A read keeps busy high for one cycle and
// the result is shown for that one cycle with result_valid_o, which the
// receiver cannot stall. A compute first clears the accumulators, one matrix
// entry per cycle, then per quadrature point forms u, accumulates the residual
// and, with the jacobian enabled, accumulates the matrix, sharing one
// multiplier and the single read ports of the stores.
// After reset the same clearing pass runs before the first command is taken.
module fem_element_mass_assembly #(
  parameter int unsigned MAX_DOFS    = fem_pkg::MAX_DOFS_DEF,
  parameter int unsigned MAX_QPOINTS = fem_pkg::MAX_QPOINTS_DEF,
  parameter int unsigned FRAC_BITS   = fem_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [2:0]                           func_i,
  input  logic [3:0]                           dof_index_i,
  input  logic [3:0]                           qp_index_i,
  input  logic [3:0]                           col_index_i,
  input  logic signed [fem_pkg::VAL_W-1:0]     value_i,
  output logic                                 result_valid_o,
  output logic signed [fem_pkg::ACC_W-1:0]     residual_value_o,
  output logic signed [fem_pkg::ACC_W-1:0]     matrix_value_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [fem_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [fem_pkg::CFG_DATA_W-1:0]       cfg_data_i
);
  import fem_pkg::*;

  localparam int unsigned DW  = (MAX_DOFS > 1) ? $clog2(MAX_DOFS) : 1;
  localparam int unsigned QW  = (MAX_QPOINTS > 1) ? $clog2(MAX_QPOINTS) : 1;
  localparam int unsigned DCW = $clog2(MAX_DOFS + 1);
  localparam int unsigned QCW = $clog2(MAX_QPOINTS + 1);
  localparam int unsigned SD  = MAX_DOFS * MAX_QPOINTS;
  localparam int unsigned SW  = (SD > 1) ? $clog2(SD) : 1;
  localparam int unsigned MD  = MAX_DOFS * MAX_DOFS;
  localparam int unsigned MW  = (MD > 1) ? $clog2(MD) : 1;

  typedef enum logic [18:0] {
    S_IDLE  = 19'h00001,
    S_READ  = 19'h00002,
    S_CLEAR = 19'h00004,
    S_QSTRT = 19'h00008,
    S_URD   = 19'h00010,
    S_UMUL  = 19'h00020,
    S_UACC  = 19'h00040,
    S_WMUL  = 19'h00080,
    S_WSAT  = 19'h00100,
    S_IRD   = 19'h00200,
    S_IMUL  = 19'h00400,
    S_IACC  = 19'h00800,
    S_PMUL  = 19'h01000,
    S_PSAT  = 19'h02000,
    S_JRD   = 19'h04000,
    S_JMUL  = 19'h08000,
    S_JACC1 = 19'h10000,
    S_JRD2  = 19'h20000,
    S_JACC2 = 19'h40000
  } state_e;

  state_e state_q, state_d;

  logic [4:0] dof_count_q, qpoint_count_q;
  logic       jac_en_q;

  logic [DCW-1:0] nd, l_q, l_d, i_q, i_d, j_q, j_d;
  logic [QCW-1:0] nq, q_q, q_d;
  logic [MW-1:0]  clr_q, clr_d;
  logic           go_q, go_d;
  logic           rd_r_ok_q, rd_m_ok_q;

  logic signed [ACC_W-1:0] u_q, u_d, term_q, term_d, mold_q, mold_d;
  logic signed [VAL_W-1:0] w_q, w_d, wu_q, wu_d, phi_q, phi_d, wp_q, wp_d;

  logic accept;
  logic d_ok, q_ok, c_ok;

  logic             coef_we, shape_we, wt_we, res_we, mat_we;
  logic [DW-1:0]    coef_raddr;
  logic [SW-1:0]    shape_waddr, shape_raddr;
  logic [QW-1:0]    wt_raddr;
  logic [DW-1:0]    res_waddr, res_raddr;
  logic [MW-1:0]    mat_waddr, mat_raddr;
  logic signed [ACC_W-1:0] res_wdata, mat_wdata;
  logic [VAL_W-1:0] coef_rd, shape_rd, wt_rd;
  logic [ACC_W-1:0] res_rd, mat_rd;
  logic [DCW-1:0]   row_sel;

  logic signed [VAL_W-1:0] mul_a, mul_b;
  logic signed [63:0]      prod;
  logic signed [ACC_W-1:0] prod_sat;
  logic signed [ACC_W-1:0] res_new, mat_new1, mat_new2;

  logic [MW-1:0] addr_ij, addr_ji;

  assign accept = start && !busy;
  assign busy   = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;

  assign d_ok = (int'(dof_index_i) < MAX_DOFS);
  assign q_ok = (int'(qp_index_i) < MAX_QPOINTS);
  assign c_ok = (int'(col_index_i) < MAX_DOFS);

  assign nd = (int'(dof_count_q) > MAX_DOFS) ? DCW'(MAX_DOFS) : DCW'(dof_count_q);
  assign nq = (int'(qpoint_count_q) > MAX_QPOINTS) ? QCW'(MAX_QPOINTS)
                                                   : QCW'(qpoint_count_q);

  assign addr_ij = MW'(int'(i_q) * MAX_DOFS + int'(j_q));
  assign addr_ji = MW'(int'(j_q) * MAX_DOFS + int'(i_q));

  always_comb begin
    row_sel = j_q;
    if (state_q == S_URD) row_sel = l_q;
    else if (state_q == S_IRD) row_sel = i_q;
  end

  assign coef_we    = accept && (func_i == FUNC_LOAD_COEF) && d_ok;
  assign shape_we   = accept && (func_i == FUNC_LOAD_SHAPE) && d_ok && q_ok;
  assign wt_we      = accept && (func_i == FUNC_LOAD_WEIGHT) && q_ok;
  assign shape_waddr = SW'(int'(dof_index_i) * MAX_QPOINTS + int'(qp_index_i));
  assign coef_raddr  = l_q[DW-1:0];
  assign shape_raddr = SW'(int'(row_sel) * MAX_QPOINTS + int'(q_q));
  assign wt_raddr    = q_q[QW-1:0];

  assign prod_sat = sat_acc(prod);
  assign res_new  = sat_acc(64'(mold_q) + 64'(prod_sat));
  assign mat_new1 = sat_acc(64'(mold_q) + 64'(prod_sat));
  assign mat_new2 = sat_acc(64'(signed'(mat_rd)) + 64'(term_q));

  always_comb begin
    res_we    = 1'b0;
    res_waddr = i_q[DW-1:0];
    res_wdata = res_new;
    mat_we    = 1'b0;
    mat_waddr = addr_ij;
    mat_wdata = mat_new1;
    if (state_q == S_CLEAR) begin
      res_we    = (int'(clr_q) < MAX_DOFS);
      res_waddr = clr_q[DW-1:0];
      res_wdata = '0;
      mat_we    = 1'b1;
      mat_waddr = clr_q;
      mat_wdata = '0;
    end else if (state_q == S_IACC) begin
      res_we = 1'b1;
    end else if (state_q == S_JACC1) begin
      mat_we = 1'b1;
    end else if (state_q == S_JACC2) begin
      mat_we    = 1'b1;
      mat_waddr = addr_ji;
      mat_wdata = mat_new2;
    end
  end

  always_comb begin
    res_raddr = i_q[DW-1:0];
    mat_raddr = addr_ij;
    if (state_q == S_IDLE) begin
      res_raddr = DW'(dof_index_i);
      mat_raddr = MW'(int'(dof_index_i) * MAX_DOFS + int'(col_index_i));
    end else if (state_q == S_JRD2) begin
      mat_raddr = addr_ji;
    end
  end

  always_comb begin
    mul_a = signed'(shape_rd);
    mul_b = signed'(coef_rd);
    case (state_q)
      S_WMUL: begin
        mul_a = w_q;
        mul_b = sat_val(64'(u_q));
      end
      S_IMUL: begin
        mul_a = wu_q;
        mul_b = signed'(shape_rd);
      end
      S_PMUL: begin
        mul_a = w_q;
        mul_b = phi_q;
      end
      S_JMUL: begin
        mul_a = wp_q;
        mul_b = signed'(shape_rd);
      end
      default: begin
      end
    endcase
  end

  fem_ram #(.WIDTH(VAL_W), .DEPTH(MAX_DOFS)) u_coef_ram (
    .clk_i, .we_i(coef_we), .waddr_i(DW'(dof_index_i)), .wdata_i(value_i),
    .raddr_i(coef_raddr), .rdata_o(coef_rd)
  );

  fem_ram #(.WIDTH(VAL_W), .DEPTH(SD)) u_shape_ram (
    .clk_i, .we_i(shape_we), .waddr_i(shape_waddr), .wdata_i(value_i),
    .raddr_i(shape_raddr), .rdata_o(shape_rd)
  );

  fem_ram #(.WIDTH(VAL_W), .DEPTH(MAX_QPOINTS)) u_wt_ram (
    .clk_i, .we_i(wt_we), .waddr_i(QW'(qp_index_i)), .wdata_i(value_i),
    .raddr_i(wt_raddr), .rdata_o(wt_rd)
  );

  fem_ram #(.WIDTH(ACC_W), .DEPTH(MAX_DOFS)) u_res_ram (
    .clk_i, .we_i(res_we), .waddr_i(res_waddr), .wdata_i(res_wdata),
    .raddr_i(res_raddr), .rdata_o(res_rd)
  );

  fem_ram #(.WIDTH(ACC_W), .DEPTH(MD)) u_mat_ram (
    .clk_i, .we_i(mat_we), .waddr_i(mat_waddr), .wdata_i(mat_wdata),
    .raddr_i(mat_raddr), .rdata_o(mat_rd)
  );

  fem_qmul #(.FRAC_BITS(FRAC_BITS)) u_qmul (
    .clk_i, .a_i(mul_a), .b_i(mul_b), .prod_o(prod)
  );

  always_comb begin
    state_d = state_q;
    l_d = l_q;
    i_d = i_q;
    j_d = j_q;
    q_d = q_q;
    clr_d = clr_q;
    go_d = go_q;
    u_d = u_q;
    w_d = w_q;
    wu_d = wu_q;
    phi_d = phi_q;
    wp_d = wp_q;
    term_d = term_q;
    mold_d = mold_q;
    case (state_q)
      S_IDLE: begin
        if (accept && func_i == FUNC_COMPUTE) begin
          state_d = S_CLEAR;
          clr_d = '0;
          go_d = 1'b1;
        end else if (accept && func_i == FUNC_READ) begin
          state_d = S_READ;
        end
      end
      S_READ: state_d = S_IDLE;
      S_CLEAR: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == MW'(MD - 1)) begin
          go_d = 1'b0;
          q_d = '0;
          state_d = (go_q && nd != '0 && nq != '0) ? S_QSTRT : S_IDLE;
        end
      end
      S_QSTRT: begin
        u_d = '0;
        l_d = '0;
        state_d = S_URD;
      end
      S_URD: begin
        w_d = signed'(wt_rd);
        state_d = S_UMUL;
      end
      S_UMUL: state_d = S_UACC;
      S_UACC: begin
        u_d = sat_acc(64'(u_q) + 64'(prod_sat));
        l_d = l_q + 1'b1;
        state_d = (l_q + 1'b1 == nd) ? S_WMUL : S_URD;
      end
      S_WMUL: state_d = S_WSAT;
      S_WSAT: begin
        wu_d = sat_val(prod);
        i_d = '0;
        state_d = S_IRD;
      end
      S_IRD: state_d = S_IMUL;
      S_IMUL: begin
        phi_d = signed'(shape_rd);
        mold_d = signed'(res_rd);
        state_d = S_IACC;
      end
      S_IACC: begin
        if (jac_en_q) begin
          state_d = S_PMUL;
        end else begin
          i_d = i_q + 1'b1;
          if (i_q + 1'b1 == nd) begin
            q_d = q_q + 1'b1;
            state_d = (q_q + 1'b1 == nq) ? S_IDLE : S_QSTRT;
          end else begin
            state_d = S_IRD;
          end
        end
      end
      S_PMUL: state_d = S_PSAT;
      S_PSAT: begin
        wp_d = sat_val(prod);
        j_d = i_q;
        state_d = S_JRD;
      end
      S_JRD: state_d = S_JMUL;
      S_JMUL: begin
        mold_d = signed'(mat_rd);
        state_d = S_JACC1;
      end
      S_JACC1, S_JACC2: begin
        if (state_q == S_JACC1) term_d = prod_sat;
        if (state_q == S_JACC1 && j_q != i_q) begin
          state_d = S_JRD2;
        end else begin
          j_d = j_q + 1'b1;
          if (j_q + 1'b1 == nd) begin
            i_d = i_q + 1'b1;
            if (i_q + 1'b1 == nd) begin
              q_d = q_q + 1'b1;
              state_d = (q_q + 1'b1 == nq) ? S_IDLE : S_QSTRT;
            end else begin
              state_d = S_IRD;
            end
          end else begin
            state_d = S_JRD;
          end
        end
      end
      S_JRD2: state_d = S_JACC2;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q <= '0;
      go_q <= 1'b0;
      l_q <= '0;
      i_q <= '0;
      j_q <= '0;
      q_q <= '0;
      rd_r_ok_q <= 1'b0;
      rd_m_ok_q <= 1'b0;
      dof_count_q <= 5'd1;
      qpoint_count_q <= 5'd1;
      jac_en_q <= 1'b1;
    end else begin
      state_q <= state_d;
      clr_q <= clr_d;
      go_q <= go_d;
      l_q <= l_d;
      i_q <= i_d;
      j_q <= j_d;
      q_q <= q_d;
      if (accept) begin
        rd_r_ok_q <= d_ok;
        rd_m_ok_q <= d_ok && c_ok;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_DOF_COUNT:    dof_count_q <= cfg_data_i[4:0];
          CFG_QPOINT_COUNT: qpoint_count_q <= cfg_data_i[4:0];
          CFG_JAC_ENABLE:   jac_en_q <= cfg_data_i[0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    u_q <= u_d;
    w_q <= w_d;
    wu_q <= wu_d;
    phi_q <= phi_d;
    wp_q <= wp_d;
    term_q <= term_d;
    mold_q <= mold_d;
  end

  assign result_valid_o   = (state_q == S_READ);
  assign residual_value_o = rd_r_ok_q ? signed'(res_rd) : '0;
  assign matrix_value_o   = rd_m_ok_q ? signed'(mat_rd) : '0;

endmodule

// ----- rtl/fem_ram.sv -----
module fem_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ----- rtl/fem_qmul.sv -----
module fem_qmul #(
  parameter int unsigned FRAC_BITS = fem_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic signed [fem_pkg::VAL_W-1:0]  a_i,
  input  logic signed [fem_pkg::VAL_W-1:0]  b_i,
  output logic signed [63:0]                prod_o
);
  import fem_pkg::*;

  logic signed [63:0] full;

  assign full = 64'(a_i) * 64'(b_i);

  always_ff @(posedge clk_i) begin
    prod_o <= full >>> FRAC_BITS;
  end

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import fem_pkg::*;

  localparam int unsigned ND = 16;
  localparam int unsigned NQ = 16;
  localparam int unsigned FB = 24;
  localparam logic [2:0] FUNC_UNUSED_FIRST = 3'd5;
  localparam logic [2:0] FUNC_UNUSED_LAST  = 3'd7;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam int unsigned IDLE_LIMIT = 200000;
  localparam int unsigned ITEM_GOAL = 750;

  typedef struct packed {
    logic [2:0]        func;
    logic [3:0]        dof;
    logic [3:0]        qp;
    logic [3:0]        col;
    logic signed [31:0] value;
  } cmd_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] residual;
    logic signed [ACC_W-1:0] matrix;
  } entry_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [2:0] func_i = '0;
  logic [3:0] dof_index_i = '0;
  logic [3:0] qp_index_i = '0;
  logic [3:0] col_index_i = '0;
  logic signed [VAL_W-1:0] value_i = '0;
  logic result_valid_o;
  logic signed [ACC_W-1:0] residual_value_o;
  logic signed [ACC_W-1:0] matrix_value_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  fem_element_mass_assembly dut (.*);

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // predictor state
  int signed coef_m [ND];
  int signed shape_m [ND*NQ];
  int signed weight_m [NQ];
  longint res_m [ND];
  longint mat_m [ND*ND];
  int unsigned dofs_m = 1, qps_m = 1, jac_m = 1;

  // generator bookkeeping
  bit coef_w [ND];
  bit shape_w [ND*NQ];
  bit weight_w [NQ];
  int unsigned gen_dofs = 1, gen_qps = 1;
  int unsigned items_made = 0;

  cmd_t pend_q [$];
  entry_t read_q [$];
  int errors = 0;
  bit hold = 1'b0;

  function automatic longint clamp(longint x, int bits);
    longint hi, lo;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    lo = -hi - 1;
    if (x > hi) return hi;
    if (x < lo) return lo;
    return x;
  endfunction

  function automatic longint qmul(int signed a, int signed b);
    longint p;
    p = longint'(a) * longint'(b);
    return p >>> FB;
  endfunction

  function automatic void accumulate(ref longint acc, input longint term);
    acc = clamp(acc + clamp(term, 40), 40);
  endfunction

  function automatic void assemble();
    int unsigned nd, nq;
    longint u;
    int signed w, wu, phi, wp;
    longint t;
    nd = dofs_m > ND ? ND : dofs_m;
    nq = qps_m > NQ ? NQ : qps_m;
    foreach (res_m[k]) res_m[k] = 0;
    foreach (mat_m[k]) mat_m[k] = 0;
    for (int q = 0; q < nq; q++) begin
      u = 0;
      w = weight_m[q];
      for (int l = 0; l < nd; l++)
        u = clamp(u + clamp(qmul(shape_m[l*NQ+q], coef_m[l]), 40), 40);
      wu = int'(clamp(qmul(w, int'(clamp(u, 32))), 32));
      for (int i = 0; i < nd; i++) begin
        phi = shape_m[i*NQ+q];
        accumulate(res_m[i], qmul(wu, phi));
        if (jac_m != 0) begin
          wp = int'(clamp(qmul(w, phi), 32));
          for (int j = i; j < nd; j++) begin
            t = qmul(wp, shape_m[j*NQ+q]);
            accumulate(mat_m[i*ND+j], t);
            if (j != i) accumulate(mat_m[j*ND+i], t);
          end
        end
      end
    end
  endfunction

  function automatic void apply_cmd(cmd_t c);
    entry_t e;
    case (c.func)
      FUNC_LOAD_COEF:   coef_m[c.dof] = c.value;
      FUNC_LOAD_SHAPE:  shape_m[c.dof*NQ + c.qp] = c.value;
      FUNC_LOAD_WEIGHT: weight_m[c.qp] = c.value;
      FUNC_COMPUTE:     assemble();
      FUNC_READ: begin
        e.residual = res_m[c.dof][ACC_W-1:0];
        e.matrix = mat_m[c.dof*ND + c.col][ACC_W-1:0];
        read_q.push_back(e);
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    errors++;
  endtask

  // driver
  int unsigned burst_left = 1, gap_left = 0;
  cmd_t cur;
  always @(posedge clk_i or negedge rst_ni) begin
    bit fire;
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      fire = start && !busy;
      if (fire) begin
        apply_cmd(cur);
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 20);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end
      if (!start || fire) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (!hold && pend_q.size() != 0) begin
          cur = pend_q.pop_front();
          func_i <= cur.func;
          dof_index_i <= cur.dof;
          qp_index_i <= cur.qp;
          col_index_i <= cur.col;
          value_i <= cur.value;
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    entry_t e;
    if (rst_ni && result_valid_o) begin
      if (read_q.size() == 0) begin
        report_mismatch("result with no read outstanding");
      end else begin
        e = read_q.pop_front();
        if (residual_value_o !== e.residual)
          report_mismatch($sformatf("residual got %h exp %h", residual_value_o, e.residual));
        if (matrix_value_o !== e.matrix)
          report_mismatch($sformatf("matrix got %h exp %h", matrix_value_o, e.matrix));
      end
    end
  end

  // watchdog
  int unsigned quiet = 0;
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || result_valid_o || (cfg_valid_i && cfg_ready_o)) begin
      quiet <= 0;
    end else if (quiet >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  function automatic logic signed [31:0] rand_value();
    case ($urandom_range(0, 7))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2, 3: return $urandom;
      default: return $signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000;
    endcase
  endfunction

  task automatic push_cmd(logic [2:0] f, logic [3:0] d, logic [3:0] q, logic [3:0] c,
                          logic signed [31:0] v);
    cmd_t x;
    x = '{func: f, dof: d, qp: q, col: c, value: v};
    case (f)
      FUNC_LOAD_COEF:   coef_w[d] = 1'b1;
      FUNC_LOAD_SHAPE:  shape_w[d*NQ + q] = 1'b1;
      FUNC_LOAD_WEIGHT: weight_w[q] = 1'b1;
      default: ;
    endcase
    pend_q.push_back(x);
    items_made++;
  endtask

  function automatic logic [3:0] pick(int unsigned n);
    if (n == 0 || $urandom_range(0, 4) == 0) return $urandom;
    return $urandom_range(0, n - 1);
  endfunction

  // one load / compute / read-back sequence for the active sizes
  task automatic gen_sequence();
    int unsigned nd, nq;
    nd = gen_dofs > ND ? ND : gen_dofs;
    nq = gen_qps > NQ ? NQ : gen_qps;
    repeat ($urandom_range(0, 6))
      push_cmd($urandom_range(FUNC_LOAD_COEF, FUNC_LOAD_WEIGHT), pick(nd), pick(nq),
               $urandom, rand_value());
    for (int l = 0; l < nd; l++)
      if (!coef_w[l]) push_cmd(FUNC_LOAD_COEF, l, $urandom, $urandom, rand_value());
    for (int l = 0; l < nd; l++)
      for (int q = 0; q < nq; q++)
        if (!shape_w[l*NQ+q]) push_cmd(FUNC_LOAD_SHAPE, l, q, $urandom, rand_value());
    for (int q = 0; q < nq; q++)
      if (!weight_w[q]) push_cmd(FUNC_LOAD_WEIGHT, $urandom, q, $urandom, rand_value());
    push_cmd(FUNC_COMPUTE, $urandom, $urandom, $urandom, $urandom);
    repeat ($urandom_range(1, 6))
      push_cmd(FUNC_READ, pick(nd), $urandom, pick(nd), $urandom);
  endtask

  task automatic gen_noise();
    logic [2:0] f;
    case ($urandom_range(0, 3))
      0: f = $urandom_range(FUNC_UNUSED_FIRST, FUNC_UNUSED_LAST);
      1: f = FUNC_READ;
      default: f = $urandom_range(FUNC_LOAD_COEF, FUNC_LOAD_WEIGHT);
    endcase
    push_cmd(f, $urandom, $urandom, $urandom, rand_value());
  endtask

  task automatic wait_idle();
    int n;
    while (pend_q.size() != 0 || read_q.size() != 0 || start) @(posedge clk_i);
    hold = 1'b1;
    n = 0;
    while (n < 8) begin
      @(posedge clk_i);
      n = busy ? 0 : n + 1;
    end
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_DOF_COUNT:    dofs_m = data[4:0];
      CFG_QPOINT_COUNT: qps_m = data[4:0];
      CFG_JAC_ENABLE:   jac_m = data[0];
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_sizes(int unsigned nd, int unsigned nq, bit jac);
    wait_idle();
    cfg_write(CFG_DOF_COUNT, ($urandom & ~32'h1F) | nd);
    cfg_write(CFG_QPOINT_COUNT, ($urandom & ~32'h1F) | nq);
    cfg_write(CFG_JAC_ENABLE, ($urandom & ~32'h1) | jac);
    gen_dofs = nd;
    gen_qps = nq;
    hold = 1'b0;
  endtask

  task automatic run_phase(int unsigned n);
    int unsigned target;
    target = items_made + n;
    while (items_made < target)
      if ($urandom_range(0, 9) < 7) gen_sequence();
      else gen_noise();
  endtask

  initial begin
    foreach (coef_m[k]) coef_m[k] = 0;
    foreach (shape_m[k]) shape_m[k] = 0;
    foreach (weight_m[k]) weight_m[k] = 0;
    foreach (res_m[k]) res_m[k] = 0;
    foreach (mat_m[k]) mat_m[k] = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset defaults, extremes, ignored codes, rereads
    push_cmd(FUNC_READ, 0, 0, 0, 0);
    push_cmd(FUNC_READ, 15, 15, 15, 0);
    push_cmd(FUNC_LOAD_COEF, 0, 0, 0, 32'sh7FFF_FFFF);
    push_cmd(FUNC_LOAD_SHAPE, 0, 0, 0, 32'sh8000_0000);
    push_cmd(FUNC_LOAD_WEIGHT, 0, 0, 0, 32'sh7FFF_FFFF);
    push_cmd(FUNC_COMPUTE, 0, 0, 0, 0);
    push_cmd(FUNC_READ, 0, 0, 0, 0);
    push_cmd(FUNC_READ, 0, 0, 15, 0);
    push_cmd(3'd5, 15, 15, 15, 32'sh8000_0000);
    push_cmd(3'd6, 0, 0, 0, 0);
    push_cmd(3'd7, 15, 15, 15, 32'sh7FFF_FFFF);
    push_cmd(FUNC_LOAD_COEF, 15, 15, 15, 32'sh8000_0000);
    push_cmd(FUNC_LOAD_SHAPE, 15, 15, 15, 32'sh7FFF_FFFF);
    push_cmd(FUNC_LOAD_WEIGHT, 15, 15, 15, 32'sh8000_0000);
    push_cmd(FUNC_LOAD_SHAPE, 0, 0, 0, 32'sh0100_0000);
    push_cmd(FUNC_LOAD_COEF, 0, 0, 0, 32'sh0200_0000);
    push_cmd(FUNC_COMPUTE, 15, 15, 15, 32'sh7FFF_FFFF);
    push_cmd(FUNC_READ, 0, 15, 0, 0);
    push_cmd(FUNC_READ, 15, 0, 0, 0);
    push_cmd(FUNC_READ, 0, 0, 15, 0);

    set_sizes(2, 2, 1);
    run_phase(40);
    set_sizes(16, 16, 1);
    gen_sequence();
    set_sizes(0, 3, 1);
    run_phase(20);
    set_sizes(31, 17, 0);
    gen_sequence();
    set_sizes(4, 0, 1);
    run_phase(20);
    wait_idle();
    cfg_write(CFG_SPARE, $urandom);
    hold = 1'b0;
    run_phase(20);
    while (items_made < ITEM_GOAL) begin
      case ($urandom_range(0, 19))
        0: set_sizes($urandom_range(5, 16), $urandom_range(1, 4), $urandom_range(0, 1));
        1: set_sizes($urandom_range(0, 31), $urandom_range(0, 3), $urandom_range(0, 1));
        default: set_sizes($urandom_range(1, 4), $urandom_range(1, 4), $urandom_range(0, 1));
      endcase
      run_phase($urandom_range(30, 60));
    end

    wait_idle();
    repeat (50) @(posedge clk_i);
    if (errors == 0 && read_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/fem_pkg.sv
rtl/fem_ram.sv
rtl/fem_qmul.sv
rtl/fem_element_mass_assembly.sv
dv/tb.sv
